@@ design/hse_pkg.sv @@
// Shared constants, state encoding and controller/datapath interface types for the heap sorter.
`default_nettype none
package hse_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int CMP_W       = ADDR_W + 2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BUILD_NEXT,
		ST_HOLD,
		ST_CHK,
		ST_RDC,
		ST_RDC2,
		ST_CMP,
		ST_XNEXT,
		ST_XRDE,
		ST_XSWAP,
		ST_EMIT_RD,
		ST_EMIT_WAIT
	} state_t;

	typedef enum logic [2:0] {
		RD_KM1,
		RD_CHILD,
		RD_CHILD1,
		RD_ROOT,
		RD_K
	} rd_sel_t;

	typedef struct packed {
		rd_sel_t rd_sel;
		logic    accept;
		logic    start_sort;
		logic    node_from_k;
		logic    load_held;
		logic    load_cur;
		logic    pick_child1;
		logic    write_held;
		logic    descend;
		logic    load_tmp;
		logic    swap_end;
		logic    k_dec;
		logic    k_from_len;
		logic    k_clear;
		logic    k_inc;
		logic    out_load;
		logic    run_clear;
	} cmd_t;

	typedef struct packed {
		logic k_zero;
		logic k_le1;
		logic child_ok;
		logic child1_ok;
		logic child_gt_held;
		logic emit_last;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

@@ design/hse_datapath.sv @@
// Heap sorter datapath: value store, sift registers, counters and output register.
`default_nettype none
module hse_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire hse_pkg::cmd_t                 cmd,
	output hse_pkg::stat_t                     stat,
	input  wire logic signed [hse_pkg::DATA_W-1:0] in_value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [hse_pkg::DATA_W-1:0]  sorted_value,
	output logic                               run_end,
	output logic                               overflowed
);
	import hse_pkg::*;

	logic [DATA_W-1:0] mem [STORE_DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [ADDR_W-1:0] rd_addr;

	logic [CNT_W-1:0]  fill_q;
	logic              drop_q;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  sift_len_q;
	logic [ADDR_W-1:0] node_q;
	logic [ADDR_W-1:0] ci_q;
	logic [DATA_W-1:0] held_q;
	logic [DATA_W-1:0] cur_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] sorted_q;
	logic              run_end_q;
	logic              ovf_q;

	logic              full;
	logic [CNT_W-1:0]  n_after;
	logic [CNT_W-1:0]  km1;
	logic [CMP_W-1:0]  child_ext;
	logic [CMP_W-1:0]  child1_ext;
	logic [CMP_W-1:0]  len_ext;

	assign full       = (fill_q == CNT_W'(STORE_DEPTH));
	assign n_after    = full ? fill_q : fill_q + CNT_W'(1);
	assign km1        = k_q - CNT_W'(1);
	assign child_ext  = CMP_W'({node_q, 1'b1});
	assign child1_ext = child_ext + CMP_W'(1);
	assign len_ext    = CMP_W'(sift_len_q);

	always_comb begin
		case (cmd.rd_sel)
			RD_KM1:    rd_addr = km1[ADDR_W-1:0];
			RD_CHILD:  rd_addr = child_ext[ADDR_W-1:0];
			RD_CHILD1: rd_addr = child1_ext[ADDR_W-1:0];
			RD_ROOT:   rd_addr = '0;
			RD_K:      rd_addr = k_q[ADDR_W-1:0];
			default:   rd_addr = k_q[ADDR_W-1:0];
		endcase
	end

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (cmd.accept && !full) begin
			mem[fill_q[ADDR_W-1:0]] <= in_value;
		end else if (cmd.write_held) begin
			mem[node_q] <= held_q;
		end else if (cmd.descend) begin
			mem[node_q] <= cur_q;
		end else if (cmd.swap_end) begin
			mem[km1[ADDR_W-1:0]] <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.run_clear) begin
				fill_q <= '0;
				drop_q <= 1'b0;
			end else if (cmd.accept) begin
				fill_q <= n_after;
				drop_q <= drop_q | full;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_sort) begin
			len_q <= n_after;
			k_q   <= n_after >> 1;
		end else if (cmd.k_from_len) begin
			k_q <= len_q;
		end else if (cmd.k_clear) begin
			k_q <= '0;
		end else if (cmd.k_dec) begin
			k_q <= km1;
		end else if (cmd.k_inc) begin
			k_q <= k_q + CNT_W'(1);
		end

		if (cmd.node_from_k) begin
			node_q     <= km1[ADDR_W-1:0];
			sift_len_q <= len_q;
		end else if (cmd.swap_end) begin
			node_q     <= '0;
			sift_len_q <= km1;
		end else if (cmd.descend) begin
			node_q <= ci_q;
		end

		if (cmd.load_held) begin
			held_q <= rd_data_q;
		end else if (cmd.swap_end) begin
			held_q <= rd_data_q;
		end

		if (cmd.load_cur) begin
			cur_q <= rd_data_q;
			ci_q  <= child_ext[ADDR_W-1:0];
		end else if (cmd.pick_child1 && ($signed(rd_data_q) > $signed(cur_q))) begin
			cur_q <= rd_data_q;
			ci_q  <= child1_ext[ADDR_W-1:0];
		end else if (cmd.load_tmp) begin
			cur_q <= rd_data_q;
		end

		if (cmd.out_load) begin
			sorted_q  <= rd_data_q;
			run_end_q <= (k_q == len_q - CNT_W'(1));
			ovf_q     <= drop_q;
		end
	end

	assign stat.k_zero        = (k_q == '0);
	assign stat.k_le1         = (k_q <= CNT_W'(1));
	assign stat.child_ok      = (child_ext < len_ext);
	assign stat.child1_ok     = (child1_ext < len_ext);
	assign stat.child_gt_held = ($signed(cur_q) > $signed(held_q));
	assign stat.emit_last     = (k_q == len_q - CNT_W'(1));
	assign stat.out_free      = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign sorted_value = $signed(sorted_q);
	assign run_end      = run_end_q;
	assign overflowed   = ovf_q;

endmodule
`default_nettype wire

@@ design/hse_ctrl.sv @@
// Heap sorter controller: load, heap build, extraction and emit sequencing.
`default_nettype none
module hse_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_last,
	output logic               in_stall,
	input  wire hse_pkg::stat_t stat,
	output hse_pkg::cmd_t      cmd
);
	import hse_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   build_q;
	logic   build_nxt;
	state_t after_sift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			build_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			build_q <= build_nxt;
		end
	end

	assign after_sift = build_q ? ST_BUILD_NEXT : ST_XNEXT;

	always_comb begin
		state_nxt = state_q;
		build_nxt = build_q;
		in_stall  = 1'b1;
		cmd       = '0;
		cmd.rd_sel = RD_K;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (in_last) begin
						cmd.start_sort = 1'b1;
						build_nxt      = 1'b1;
						state_nxt      = ST_BUILD_NEXT;
					end
				end
			end
			ST_BUILD_NEXT: begin
				if (stat.k_zero) begin
					cmd.k_from_len = 1'b1;
					build_nxt      = 1'b0;
					state_nxt      = ST_XNEXT;
				end else begin
					cmd.rd_sel      = RD_KM1;
					cmd.node_from_k = 1'b1;
					state_nxt       = ST_HOLD;
				end
			end
			ST_HOLD: begin
				cmd.load_held = 1'b1;
				state_nxt     = ST_CHK;
			end
			ST_CHK: begin
				if (stat.child_ok) begin
					cmd.rd_sel = RD_CHILD;
					state_nxt  = ST_RDC;
				end else begin
					cmd.write_held = 1'b1;
					cmd.k_dec      = 1'b1;
					state_nxt      = after_sift;
				end
			end
			ST_RDC: begin
				cmd.load_cur = 1'b1;
				if (stat.child1_ok) begin
					cmd.rd_sel = RD_CHILD1;
					state_nxt  = ST_RDC2;
				end else begin
					state_nxt = ST_CMP;
				end
			end
			ST_RDC2: begin
				cmd.pick_child1 = 1'b1;
				state_nxt       = ST_CMP;
			end
			ST_CMP: begin
				if (stat.child_gt_held) begin
					cmd.descend = 1'b1;
					state_nxt   = ST_CHK;
				end else begin
					cmd.write_held = 1'b1;
					cmd.k_dec      = 1'b1;
					state_nxt      = after_sift;
				end
			end
			ST_XNEXT: begin
				if (stat.k_le1) begin
					cmd.k_clear = 1'b1;
					state_nxt   = ST_EMIT_RD;
				end else begin
					cmd.rd_sel = RD_ROOT;
					state_nxt  = ST_XRDE;
				end
			end
			ST_XRDE: begin
				// root value parked in cur while the heap end is fetched
				cmd.load_tmp = 1'b1;
				cmd.rd_sel   = RD_KM1;
				state_nxt    = ST_XSWAP;
			end
			ST_XSWAP: begin
				cmd.swap_end = 1'b1;
				state_nxt    = ST_CHK;
			end
			ST_EMIT_RD: begin
				state_nxt = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (stat.emit_last) begin
						cmd.run_clear = 1'b1;
						state_nxt     = ST_IDLE;
					end else begin
						cmd.k_inc = 1'b1;
						state_nxt = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/heap_sort_engine_unit.sv @@
// Top level of the heap sort engine: controller plus datapath.
`default_nettype none
// Values enter one per cycle into a 64-entry store; a transaction with in_last set
// closes the set and starts an in-place heapsort (max-heap build, then root/end swaps),
// after which the values leave in ascending order, run_end on the final one and
// overflowed on every one if values past the store depth were dropped. The store has
// one write and one registered read port, so each sift level steps through reading
// the left child, reading the right child where there is one, and comparing and moving;
// emission reads each value and then waits until the output register is free for it.
// Input is stalled from the last value of a set until its final result is registered;
// the next set may load while that result still waits on the output.
module heap_sort_engine_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [hse_pkg::DATA_W-1:0]  in_value,
	input  wire logic                               in_last,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [hse_pkg::DATA_W-1:0]       sorted_value,
	output logic                                    run_end,
	output logic                                    overflowed
);
	import hse_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	hse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_last),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	hse_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_value     (in_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.run_end      (run_end),
		.overflowed   (overflowed)
	);

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for heap_sort_engine_unit: random and directed sets, ascending order check.
`timescale 1ns / 1ps

typedef logic signed [hse_pkg::DATA_W-1:0] word_t;

typedef struct packed {
	word_t value;
	logic  run_end;
	logic  overflowed;
} sorted_t;

// Keeps its own copy of the store and predicts the ascending output of every set.
class ascending_tracker;
	word_t   store [hse_pkg::STORE_DEPTH];
	int      fill = 0;
	bit      dropped = 0;
	sorted_t sorted_due[$];
	int      errors = 0;
	int      runs = 0;
	int      overflow_runs = 0;
	int      values_in = 0;
	int      values_out = 0;

	function void sift_down(int node, int len);
		word_t held;
		int    child;
		held  = store[node];
		child = 2 * node + 1;
		while (child < len) begin
			if (child + 1 < len && store[child + 1] > store[child])
				child++;
			if (!(store[child] > held))
				break;
			store[node] = store[child];
			node        = child;
			child       = 2 * node + 1;
		end
		store[node] = held;
	endfunction

	function void heap_sort(int len);
		word_t tmp;
		for (int k = len / 2; k > 0; k--)
			sift_down(k - 1, len);
		for (int k = len; k > 1; k--) begin
			tmp          = store[0];
			store[0]     = store[k - 1];
			store[k - 1] = tmp;
			sift_down(0, k - 1);
		end
	endfunction

	// Called on every accepted input transaction.
	function void take_value(word_t v, logic last);
		sorted_t r;
		values_in++;
		if (fill < hse_pkg::STORE_DEPTH) begin
			store[fill] = v;
			fill++;
		end else begin
			dropped = 1;
		end
		if (last) begin
			heap_sort(fill);
			for (int k = 0; k < fill; k++) begin
				r.value      = store[k];
				r.run_end    = (k + 1 == fill);
				r.overflowed = dropped;
				sorted_due.push_back(r);
			end
			runs++;
			if (dropped)
				overflow_runs++;
			fill    = 0;
			dropped = 0;
		end
	endfunction

	task report(string msg);
		errors++;
		$display("MISMATCH: %s", msg);
	endtask

	// Called on every accepted output transaction.
	task check_sorted(word_t v, logic fin, logic ovf);
		sorted_t e;
		if (sorted_due.size() == 0) begin
			report($sformatf("unexpected result value=%0d run_end=%0b", v, fin));
			return;
		end
		e = sorted_due.pop_front();
		values_out++;
		if (v !== e.value)
			report($sformatf("sorted_value %0d, predicted %0d", v, e.value));
		if (fin !== e.run_end)
			report($sformatf("run_end %0b, predicted %0b (value %0d)", fin, e.run_end, v));
		if (ovf !== e.overflowed)
			report($sformatf("overflowed %0b, predicted %0b (value %0d)", ovf, e.overflowed, v));
	endtask
endclass

module testbench;
	localparam int IDLE_LIMIT = 20000;
	localparam int LONG_HOLD  = 400;
	localparam int TAIL       = 40;

	logic  clk = 0;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	word_t in_value;
	logic  in_last;
	logic  out_valid;
	logic  out_stall;
	word_t sorted_value;
	logic  run_end;
	logic  overflowed;

	ascending_tracker sb;
	bit quiet;
	bit hold_req;
	int idle_cycles;
	int stall_left;

	heap_sort_engine_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_value     (in_value),
		.in_last      (in_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.run_end      (run_end),
		.overflowed   (overflowed)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// mostly short gaps, a few long ones
	function int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function word_t pick_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 0;
					default: return -1;
				endcase
			end
			1, 2: return int'($urandom_range(0, 15)) - 8;
			default: return $urandom;
		endcase
	endfunction

	task send_item(word_t v, logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_value <= v;
		in_last  <= last;
		do @(posedge clk); while (in_stall);
		sb.take_value(v, last);
	endtask

	task send_set(word_t vals[$]);
		foreach (vals[i])
			send_item(vals[i], i == vals.size() - 1);
	endtask

	task send_random_set(int size);
		word_t vals[$];
		repeat (size) vals.push_back(pick_value());
		send_set(vals);
	endtask

	task wait_drained();
		in_valid <= 0;
		while (sb.sorted_due.size() != 0) @(posedge clk);
	endtask

	// result side: check accepted transactions, then decide the next stall
	initial begin
		out_stall  = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_sorted(sorted_value, run_end, overflowed);
			if (hold_req) begin
				hold_req   = 0;
				stall_left = LONG_HOLD;
			end else if (stall_left > 0) begin
				stall_left--;
			end else begin
				stall_left = pick_gap();
			end
			out_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("heap_sort_engine_unit test failed");
				$finish;
			end
		end
	end

	initial begin
		int rand_items;
		int set_idx;
		int size;
		sb       = new;
		arst_n   = 0;
		in_valid = 0;
		in_value = 0;
		in_last  = 0;
		quiet    = 0;
		hold_req = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: single-value sets, extremes with duplicates, tiny sets, bit patterns
		send_set('{32'sh7fff_ffff});
		send_set('{32'sh8000_0000});
		send_set('{32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 1, 32'sh7fff_ffff,
			32'sh8000_0000, 0});
		send_set('{-5, 5});
		send_set('{5, -5});
		send_set('{32'sh5555_5555, 32'shaaaa_aaaa});
		wait_drained();

		// receiver holds off while the sender keeps offering: the block backs up
		quiet    = 1;
		hold_req = 1;
		send_random_set(6);
		send_random_set(6);
		quiet = 0;
		wait_drained();

		// one random set, then a set that exactly fills the store, then one that overflows it
		rand_items = 0;
		set_idx    = 0;
		while (rand_items < 110) begin
			if (set_idx == 1)
				size = hse_pkg::STORE_DEPTH;
			else if (set_idx == 2)
				size = $urandom_range(hse_pkg::STORE_DEPTH + 1, hse_pkg::STORE_DEPTH + 2);
			else if ($urandom_range(0, 9) == 0)
				size = $urandom_range(13, 40);
			else
				size = $urandom_range(1, 12);
			quiet = ($urandom_range(0, 4) == 0);
			send_random_set(size);
			rand_items += size;
			set_idx++;
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end
		quiet = 0;
		wait_drained();
		repeat (TAIL) @(posedge clk);

		if (sb.sorted_due.size() != 0)
			sb.report($sformatf("%0d predicted results never arrived", sb.sorted_due.size()));
		$display("covered %0d sets (%0d with dropped values), %0d values in, %0d sorted out",
			sb.runs, sb.overflow_runs, sb.values_in, sb.values_out);
		$display("mismatches counted: %0d", sb.errors);
		if (sb.errors == 0)
			$display("heap_sort_engine_unit test passed");
		else
			$display("heap_sort_engine_unit test failed");
		$finish;
	end
endmodule
